[hdl/enc_pkg.sv]
// Shared constants and types for the encoder position and speed block.
// No dependencies; imported by enc_div and encoder_position_and_rpm.
package enc_pkg;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_SPEED = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;

  localparam int POS_W   = 32;
  localparam int CPR_W   = 16;
  localparam int DIV_W   = POS_W + CPR_W;
  localparam int CNT_W   = $clog2(DIV_W);

  localparam logic [CPR_W-1:0] MS_PER_MINUTE = 16'd60000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/enc_div.sv]
// Restoring unsigned divider that retires one quotient bit per cycle.
// Depends on enc_pkg for widths and the request/response structs.
module enc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  enc_pkg::div_req_t req,
  output enc_pkg::div_rsp_t rsp
);
  import enc_pkg::*;

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;

  // One shift and one trial subtraction per step.
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = CNT_W'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIV_W]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r && $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider finished without a running division");

  property p_start_when_idle;
    @(posedge clk) disable iff (!rst_n) req.start |-> !busy_r;
  endproperty
  a_start_when_idle: assert property (p_start_when_idle)
    else $error("divider restarted while busy");

  property p_rem_below_den;
    @(posedge clk) disable iff (!rst_n) (busy_r && den_r != '0) |-> rem_r < den_r;
  endproperty
  a_rem_below_den: assert property (p_rem_below_den)
    else $error("partial remainder reached the divisor");

endmodule

[hdl/encoder_position_and_rpm.sv]
// Encoder position counter with speed measurement in revolutions per minute.
// Edge, set and unused beats give their result in the cycle after acceptance. A speed beat
// runs both multiplies, the divider start, the divider steps, the done check and the output
// load, ending after the start if no time has passed or the scale is zero. Other beats are
// taken one per cycle while the output slot is free or emptying; none during a speed beat.
// Reset is synchronous and active low; position and sample state clear, pulses per rev = 1.
module encoder_position_and_rpm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [enc_pkg::CPR_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic                              in_count_down,
  input  logic [enc_pkg::POS_W-1:0]         in_now_ms,
  input  logic signed [enc_pkg::POS_W-1:0]  in_new_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [enc_pkg::POS_W-1:0]  out_position_out,
  output logic signed [enc_pkg::POS_W-1:0]  out_rpm,
  output logic                              out_rpm_valid
);
  import enc_pkg::*;

  // Sequencer states. IDLE is the only state in which a beat is taken.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_NUM = 3'd1;
  localparam logic [2:0] ST_MUL_DEN = 3'd2;
  localparam logic [2:0] ST_START   = 3'd3;
  localparam logic [2:0] ST_DIV     = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CPR_W-1:0] cpr_r;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [POS_W-1:0] last_pos_r, last_pos_nxt;
  logic [POS_W-1:0] last_time_r, last_time_nxt;

  // Speed beat operands: num and den come from the multiplier, the rest from acceptance.
  logic [POS_W-1:0] mag_r, mag_nxt;
  logic [POS_W-1:0] dt_r, dt_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] pos_out_r, pos_out_nxt;
  logic [POS_W-1:0] rpm_r, rpm_nxt;
  logic             rpm_valid_r, rpm_valid_nxt;

  logic             accept;
  logic [POS_W-1:0] diff;
  logic [POS_W-1:0] dt_now;
  logic [POS_W-1:0] mul_a;
  logic [CPR_W-1:0] mul_b;
  logic [DIV_W-1:0] mul_p;
  logic             sat_pos;
  logic             sat_neg;
  logic [POS_W-1:0] rpm_final;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // A beat is taken only while idle and with the output slot free or emptying.
  // Since the slot is empty after acceptance and nothing else writes it, a speed
  // result always finds the slot free when the divider completes.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign diff   = position_r - last_pos_r;
  assign dt_now = in_now_ms - last_time_r;

  // The single 32x16 multiplier forms the numerator delta*60000 in ST_MUL_NUM
  // and then the divisor dt*counts_per_rev in ST_MUL_DEN.
  assign mul_a = (state_r == ST_MUL_NUM) ? mag_r : dt_r;
  assign mul_b = (state_r == ST_MUL_NUM) ? MS_PER_MINUTE : cpr_r;
  assign mul_p = {{CPR_W{1'b0}}, mul_a} * {{POS_W{1'b0}}, mul_b};

  assign div_req.start = (state_r == ST_START) && !zero_r;
  assign div_req.num   = num_r;
  assign div_req.den   = den_r;

  enc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Saturation: a positive speed clips at 2^31-1, a negative one at -2^31.
  assign sat_pos   = div_rsp.quot[DIV_W-1:POS_W-1] != '0;
  assign sat_neg   = (div_rsp.quot[DIV_W-1:POS_W] != '0) ||
                     (div_rsp.quot[POS_W-1] && (div_rsp.quot[POS_W-2:0] != '0));
  always_comb begin
    if (!neg_r) begin
      rpm_final = sat_pos ? {1'b0, {(POS_W-1){1'b1}}} : div_rsp.quot[POS_W-1:0];
    end else begin
      rpm_final = sat_neg ? {1'b1, {(POS_W-1){1'b0}}} : (~div_rsp.quot[POS_W-1:0] + 1'b1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    position_nxt  = position_r;
    last_pos_nxt  = last_pos_r;
    last_time_nxt = last_time_r;
    mag_nxt       = mag_r;
    dt_nxt        = dt_r;
    neg_nxt       = neg_r;
    zero_nxt      = zero_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_out_nxt   = pos_out_r;
    rpm_nxt       = rpm_r;
    rpm_valid_nxt = rpm_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_EDGE: begin
              position_nxt  = in_count_down ? position_r - 1'b1 : position_r + 1'b1;
              out_valid_nxt = 1'b1;
              pos_out_nxt   = position_nxt;
              rpm_nxt       = '0;
              rpm_valid_nxt = 1'b0;
            end
            KIND_SPEED: begin
              // The sample point moves on every speed beat, even one with no time.
              last_pos_nxt  = position_r;
              last_time_nxt = in_now_ms;
              neg_nxt       = diff[POS_W-1];
              mag_nxt       = diff[POS_W-1] ? (~diff + 1'b1) : diff;
              dt_nxt        = dt_now;
              zero_nxt      = (dt_now == '0) || (cpr_r == '0);
              state_nxt     = ST_MUL_NUM;
            end
            KIND_SET: begin
              position_nxt  = $unsigned(in_new_position);
              out_valid_nxt = 1'b1;
              pos_out_nxt   = position_nxt;
              rpm_nxt       = '0;
              rpm_valid_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              pos_out_nxt   = position_r;
              rpm_nxt       = '0;
              rpm_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_MUL_NUM: begin
        num_nxt   = mul_p;
        state_nxt = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        den_nxt   = mul_p;
        state_nxt = ST_START;
      end
      ST_START: begin
        if (zero_r) begin
          // No elapsed time or no scale: report the position with no speed.
          out_valid_nxt = 1'b1;
          pos_out_nxt   = position_r;
          rpm_nxt       = '0;
          rpm_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          pos_out_nxt   = position_r;
          rpm_nxt       = rpm_final;
          rpm_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cpr_r       <= CPR_W'(1);
      position_r  <= '0;
      last_pos_r  <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      last_pos_r  <= last_pos_nxt;
      last_time_r <= last_time_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cpr_r <= cfg_wr_data;
      end
    end
    mag_r       <= mag_nxt;
    dt_r        <= dt_nxt;
    neg_r       <= neg_nxt;
    zero_r      <= zero_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    pos_out_r   <= pos_out_nxt;
    rpm_r       <= rpm_nxt;
    rpm_valid_r <= rpm_valid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_position_out = $signed(pos_out_r);
  assign out_rpm          = $signed(rpm_r);
  assign out_rpm_valid    = rpm_valid_r;

  // A finished division must never land on an occupied output slot.
  property p_done_slot_free;
    @(posedge clk) disable iff (!rst_n) div_rsp.done |-> !out_valid_r && (state_r == ST_DIV);
  endproperty
  a_done_slot_free: assert property (p_done_slot_free)
    else $error("speed result would overwrite a pending beat");

  // The position cannot move while a speed beat is being worked on.
  property p_position_held;
    @(posedge clk) disable iff (!rst_n) (state_r != ST_IDLE) |=> $stable(position_r);
  endproperty
  a_position_held: assert property (p_position_held)
    else $error("position changed during a speed computation");

  // A speed beat blocks the input in the following cycle.
  property p_speed_blocks;
    @(posedge clk) disable iff (!rst_n) (accept && in_kind == KIND_SPEED) |=> !in_ready;
  endproperty
  a_speed_blocks: assert property (p_speed_blocks)
    else $error("input ready right after a speed beat");

  // Without a valid speed the reported rpm is zero.
  property p_rpm_zero;
    @(posedge clk) disable iff (!rst_n) (out_valid_r && !rpm_valid_r) |-> rpm_r == '0;
  endproperty
  a_rpm_zero: assert property (p_rpm_zero)
    else $error("nonzero rpm reported without a valid speed");

endmodule
